### rtl/core/rans2_pkg.sv
// Package: widths, constants and control types of the two-way rANS encoder
`default_nettype none
package rans2_pkg;

    localparam int STATE_W = 32;
    localparam int WORD_W  = 16;
    localparam int CNT_W   = $clog2(STATE_W);

    localparam logic [STATE_W-1:0] STATE_INIT = 32'h0000_8000;
    localparam logic [WORD_W-1:0]  TOTAL_INIT = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RENORM,
        S_DIV,
        S_MUL,
        S_COMMIT,
        S_FLUSH_ODD,
        S_FLUSH_EVEN
    } t_state;

    typedef enum logic [1:0] {
        SRC_RENORM,
        SRC_ODD,
        SRC_EVEN
    } t_out_src;

    typedef struct packed {
        logic     capture;
        logic     load_div;
        logic     div_step;
        logic     mul;
        logic     commit;
        logic     flush_clear;
        logic     out_load;
        t_out_src out_src;
    } t_cmd;

    typedef struct packed {
        logic is_flush;
        logic need_renorm;
        logic out_free;
        logic div_last;
    } t_stat;

endpackage
`default_nettype wire

### rtl/core/rans2_ifs.sv
// Interfaces: symbol request, output word request and configuration write channels
`default_nettype none
interface rans2_sym_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] freq;
    logic [15:0] cum;
    modport source (output valid, output mode, output freq, output cum, input ready);
    modport sink   (input valid, input mode, input freq, input cum, output ready);
endinterface

interface rans2_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;
    logic        last;
    modport source (output valid, output word, output last, input ready);
    modport sink   (input valid, input word, input last, output ready);
endinterface

interface rans2_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/rans2_ctrl.sv
// Controller: sequences capture, renormalization, division, coding and flush
`default_nettype none
module rans2_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  rans2_pkg::t_stat    i_stat,
    output logic                o_in_ready,
    output rans2_pkg::t_cmd     o_cmd
);

    rans2_pkg::t_state r_state;
    rans2_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rans2_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rans2_pkg::S_IDLE: begin
                if (i_in_valid) n_state = rans2_pkg::S_DECODE;
            end
            rans2_pkg::S_DECODE: begin
                n_state = i_stat.is_flush ? rans2_pkg::S_FLUSH_ODD : rans2_pkg::S_RENORM;
            end
            rans2_pkg::S_RENORM: begin
                if (!i_stat.need_renorm || i_stat.out_free) n_state = rans2_pkg::S_DIV;
            end
            rans2_pkg::S_DIV: begin
                if (i_stat.div_last) n_state = rans2_pkg::S_MUL;
            end
            rans2_pkg::S_MUL: begin
                n_state = rans2_pkg::S_COMMIT;
            end
            rans2_pkg::S_COMMIT: begin
                n_state = rans2_pkg::S_IDLE;
            end
            rans2_pkg::S_FLUSH_ODD: begin
                if (i_stat.out_free) n_state = rans2_pkg::S_FLUSH_EVEN;
            end
            rans2_pkg::S_FLUSH_EVEN: begin
                if (i_stat.out_free) n_state = rans2_pkg::S_IDLE;
            end
            default: begin
                n_state = rans2_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready          = 1'b0;
        o_cmd.capture       = 1'b0;
        o_cmd.load_div      = 1'b0;
        o_cmd.div_step      = 1'b0;
        o_cmd.mul           = 1'b0;
        o_cmd.commit        = 1'b0;
        o_cmd.flush_clear   = 1'b0;
        o_cmd.out_load      = 1'b0;
        o_cmd.out_src       = rans2_pkg::SRC_RENORM;
        case (r_state)
            rans2_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            rans2_pkg::S_RENORM: begin
                if (!i_stat.need_renorm || i_stat.out_free) begin
                    o_cmd.load_div = 1'b1;
                    o_cmd.out_load = i_stat.need_renorm;
                end
            end
            rans2_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            rans2_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            rans2_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
            end
            rans2_pkg::S_FLUSH_ODD: begin
                o_cmd.out_src  = rans2_pkg::SRC_ODD;
                o_cmd.out_load = i_stat.out_free;
            end
            rans2_pkg::S_FLUSH_EVEN: begin
                o_cmd.out_src     = rans2_pkg::SRC_EVEN;
                o_cmd.out_load    = i_stat.out_free;
                o_cmd.flush_clear = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/rans2_dp.sv
// Datapath: coder states, radix-2 divider, multiply-add and output word register
`default_nettype none
module rans2_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  rans2_pkg::t_cmd                     i_cmd,
    input  wire                                 i_in_mode,
    input  wire  [rans2_pkg::WORD_W-1:0]        i_in_freq,
    input  wire  [rans2_pkg::WORD_W-1:0]        i_in_cum,
    input  wire                                 i_cfg_we,
    input  wire  [rans2_pkg::WORD_W-1:0]        i_cfg_data,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic [rans2_pkg::WORD_W-1:0]        o_out_word,
    output logic                                o_out_last,
    output rans2_pkg::t_stat                    o_stat
);

    logic [rans2_pkg::STATE_W-1:0] r_st_odd;
    logic [rans2_pkg::STATE_W-1:0] r_st_even;
    logic                          r_use_odd;
    logic [rans2_pkg::WORD_W-1:0]  r_total;
    logic                          r_mode;
    logic [rans2_pkg::WORD_W-1:0]  r_freq;
    logic [rans2_pkg::WORD_W-1:0]  r_cum;
    logic [rans2_pkg::STATE_W-1:0] r_quo;
    logic [rans2_pkg::STATE_W-1:0] r_rem;
    logic [rans2_pkg::CNT_W-1:0]   r_cnt;
    logic [rans2_pkg::STATE_W-1:0] r_prod;
    logic                          r_out_valid;
    logic [rans2_pkg::WORD_W-1:0]  r_word;
    logic                          r_last;

    logic [rans2_pkg::STATE_W-1:0] w_sel;
    logic [rans2_pkg::STATE_W-1:0] w_limit;
    logic                          w_need;
    logic [rans2_pkg::STATE_W:0]   w_trial;
    logic [rans2_pkg::STATE_W:0]   w_diff;
    logic                          w_ge;
    logic [rans2_pkg::STATE_W+rans2_pkg::WORD_W-1:0] w_mul;
    logic [rans2_pkg::STATE_W-1:0] w_coded;
    logic [rans2_pkg::WORD_W-1:0]  w_out_word;

    assign w_sel   = r_use_odd ? r_st_odd : r_st_even;
    assign w_limit = {r_freq, {rans2_pkg::WORD_W{1'b0}}};
    assign w_need  = (w_sel >= w_limit);
    assign w_trial = {r_rem, r_quo[rans2_pkg::STATE_W-1]};
    assign w_ge    = (w_trial >= {{(rans2_pkg::STATE_W+1-rans2_pkg::WORD_W){1'b0}}, r_freq});
    assign w_diff  = w_trial - {{(rans2_pkg::STATE_W+1-rans2_pkg::WORD_W){1'b0}}, r_freq};
    assign w_mul   = r_quo * r_total;
    assign w_coded = r_prod + r_rem + {{(rans2_pkg::STATE_W-rans2_pkg::WORD_W){1'b0}}, r_cum};

    always_comb begin
        case (i_cmd.out_src)
            rans2_pkg::SRC_RENORM: w_out_word = w_sel[rans2_pkg::WORD_W-1:0];
            rans2_pkg::SRC_ODD:    w_out_word = r_st_odd[rans2_pkg::WORD_W-1:0];
            rans2_pkg::SRC_EVEN:   w_out_word = r_st_even[rans2_pkg::WORD_W-1:0];
            default:               w_out_word = w_sel[rans2_pkg::WORD_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_odd    <= rans2_pkg::STATE_INIT;
            r_st_even   <= rans2_pkg::STATE_INIT;
            r_use_odd   <= 1'b1;
            r_total     <= rans2_pkg::TOTAL_INIT;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) r_total <= i_cfg_data;
            if (i_cmd.load_div) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_use_odd) r_st_odd <= w_coded;
                else           r_st_even <= w_coded;
                r_use_odd <= ~r_use_odd;
            end
            if (i_cmd.flush_clear) begin
                r_st_odd  <= rans2_pkg::STATE_INIT;
                r_st_even <= rans2_pkg::STATE_INIT;
                r_use_odd <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_in_mode;
            r_freq <= i_in_freq;
            r_cum  <= i_in_cum;
        end
        if (i_cmd.load_div) begin
            r_quo <= w_need ? (w_sel >> rans2_pkg::WORD_W) : w_sel;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[rans2_pkg::STATE_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[rans2_pkg::STATE_W-1:0] : w_trial[rans2_pkg::STATE_W-1:0];
        end
        if (i_cmd.mul) r_prod <= w_mul[rans2_pkg::STATE_W-1:0];
        if (i_cmd.out_load) begin
            r_word <= w_out_word;
            r_last <= (i_cmd.out_src == rans2_pkg::SRC_EVEN);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_word         = r_word;
    assign o_out_last         = r_last;
    assign o_stat.is_flush    = r_mode;
    assign o_stat.need_renorm = w_need;
    assign o_stat.out_free    = ~r_out_valid | i_out_ready;
    assign o_stat.div_last    = &r_cnt;

endmodule
`default_nettype wire

### rtl/core/rans_encoder_two_way_interleaved.sv
// Top level: two-way interleaved rANS encoder with 16-bit renormalization
// Symbol: one request at a time (accept, decode, renorm, 32 divider steps,
//   multiply, commit); renorm waits while an output word is still untaken.
// A renorm word, when needed, is loaded into the output register in the renorm state after decode.
// Flush: after decode, the odd then the even state's low word (marked last) are output; a stall holds either.
// Reset: synchronous active low; both states to 0x8000, odd state first, total 65535.
`default_nettype none
module rans_encoder_two_way_interleaved (
    input  wire              i_clk,
    input  wire              i_rst_n,
    rans2_cfg_if.sink        i_cfg,
    rans2_sym_if.sink        i_sym,
    rans2_word_if.source     o_word
);

    rans2_pkg::t_cmd  w_cmd;
    rans2_pkg::t_stat w_stat;
    logic             w_in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_sym.ready = w_in_ready;

    rans2_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sym.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    rans2_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_mode   (i_sym.mode),
        .i_in_freq   (i_sym.freq),
        .i_in_cum    (i_sym.cum),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_word.ready),
        .o_out_valid (o_word.valid),
        .o_out_word  (o_word.word),
        .o_out_last  (o_word.last),
        .o_stat      (w_stat)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sym.valid && i_sym.ready) |=> !i_sym.ready)
        else $error("request accepted while previous symbol still in work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("output word overwritten before taken");

    a_mul_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mul |-> ($past(w_cmd.div_step) && $past(w_stat.div_last)))
        else $error("multiply started before divider finished");

endmodule
`default_nettype wire
